// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the reference count table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("reference count table check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("reference count table check failed");

`endif

// File: hw/rtl/rct_pkg.sv
// Types, micro-program codes and the control store of the reference count table.
`timescale 1ns / 1ps
package rct_pkg;

	localparam int STEP_W = 4;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [3:0]        act_t;
	typedef logic [3:0]        cond_t;

	// Program steps.
	localparam step_t S_IDLE      = 4'd0;
	localparam step_t S_DISPATCH  = 4'd1;
	localparam step_t S_SETUP_OLD = 4'd2;
	localparam step_t S_RD_OLD    = 4'd3;
	localparam step_t S_CMP_OLD   = 4'd4;
	localparam step_t S_SETUP_NEW = 4'd5;
	localparam step_t S_RD_NEW    = 4'd6;
	localparam step_t S_CMP_NEW   = 4'd7;
	localparam step_t S_DONE      = 4'd8;
	localparam step_t S_DEC       = 4'd9;
	localparam step_t S_FREE_RD   = 4'd10;
	localparam step_t S_FREE_WR   = 4'd11;
	localparam step_t S_INC       = 4'd12;
	localparam step_t S_REG       = 4'd13;

	// Datapath actions.
	localparam act_t ACT_NONE      = 4'd0;
	localparam act_t ACT_SETUP_OLD = 4'd1;
	localparam act_t ACT_SETUP_NEW = 4'd2;
	localparam act_t ACT_CMP       = 4'd3;
	localparam act_t ACT_DEC       = 4'd4;
	localparam act_t ACT_FREE_RD   = 4'd5;
	localparam act_t ACT_FREE_WR   = 4'd6;
	localparam act_t ACT_INC       = 4'd7;
	localparam act_t ACT_REG       = 4'd8;
	localparam act_t ACT_DONE      = 4'd9;

	// Jump conditions.
	localparam cond_t C_NEVER       = 4'd0;
	localparam cond_t C_ALWAYS      = 4'd1;
	localparam cond_t C_NO_START    = 4'd2;
	localparam cond_t C_KIND_REG    = 4'd3;
	localparam cond_t C_OLD_SKIP    = 4'd4;
	localparam cond_t C_NEW_SKIP    = 4'd5;
	localparam cond_t C_MATCH       = 4'd6;
	localparam cond_t C_MATCH_UNSAT = 4'd7;
	localparam cond_t C_CNT_NOT_ONE = 4'd8;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t tgt;
		logic  loop;
	} ctrl_t;

	typedef struct packed {
		logic start;
		logic kind;
		logic old_skip;
		logic new_skip;
		logic match;
		logic unsat;
		logic cnt_one;
		logic more;
	} flags_t;

	function automatic ctrl_t mk(input act_t a, input cond_t c, input step_t t, input logic l);
		ctrl_t w;
		w.act  = a;
		w.cond = c;
		w.tgt  = t;
		w.loop = l;
		return w;
	endfunction

	// The control store: one word per step.
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		case (step)
			S_IDLE:      w = mk(ACT_NONE,      C_NO_START,    S_IDLE,      1'b0);
			S_DISPATCH:  w = mk(ACT_NONE,      C_KIND_REG,    S_REG,       1'b0);
			S_SETUP_OLD: w = mk(ACT_SETUP_OLD, C_OLD_SKIP,    S_SETUP_NEW, 1'b0);
			S_RD_OLD:    w = mk(ACT_NONE,      C_NEVER,       S_IDLE,      1'b0);
			S_CMP_OLD:   w = mk(ACT_CMP,       C_MATCH,       S_DEC,       1'b1);
			S_SETUP_NEW: w = mk(ACT_SETUP_NEW, C_NEW_SKIP,    S_DONE,      1'b0);
			S_RD_NEW:    w = mk(ACT_NONE,      C_NEVER,       S_IDLE,      1'b0);
			S_CMP_NEW:   w = mk(ACT_CMP,       C_MATCH_UNSAT, S_INC,       1'b1);
			S_DONE:      w = mk(ACT_DONE,      C_ALWAYS,      S_IDLE,      1'b0);
			S_DEC:       w = mk(ACT_DEC,       C_CNT_NOT_ONE, S_SETUP_NEW, 1'b0);
			S_FREE_RD:   w = mk(ACT_FREE_RD,   C_NEVER,       S_IDLE,      1'b0);
			S_FREE_WR:   w = mk(ACT_FREE_WR,   C_ALWAYS,      S_SETUP_NEW, 1'b0);
			S_INC:       w = mk(ACT_INC,       C_ALWAYS,      S_DONE,      1'b0);
			S_REG:       w = mk(ACT_REG,       C_ALWAYS,      S_DONE,      1'b0);
			default:     w = mk(ACT_NONE,      C_ALWAYS,      S_IDLE,      1'b0);
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/rct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module rct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/rct_seq.sv
// Micro-sequencer: step counter, control store and conditional jump logic.
`timescale 1ns / 1ps
module rct_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  rct_pkg::flags_t flags,
	output rct_pkg::ctrl_t  ctrl,
	output logic           busy
);
	import rct_pkg::*;

	step_t step_q;
	step_t step_d;
	logic  taken;

	assign ctrl = ucode(step_q);
	assign busy = (step_q != S_IDLE);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:       taken = 1'b0;
			C_ALWAYS:      taken = 1'b1;
			C_NO_START:    taken = !flags.start;
			C_KIND_REG:    taken = !flags.kind;
			C_OLD_SKIP:    taken = flags.old_skip;
			C_NEW_SKIP:    taken = flags.new_skip;
			C_MATCH:       taken = flags.match;
			C_MATCH_UNSAT: taken = flags.match && flags.unsat;
			C_CNT_NOT_ONE: taken = !flags.cnt_one;
			default:       taken = 1'b0;
		endcase
	end

	always_comb begin
		if (taken) begin
			step_d = ctrl.tgt;
		end else if (ctrl.loop && !flags.match && flags.more) begin
			// Scan not finished: go back to the read step for the next entry.
			step_d = step_q - step_t'(1);
		end else begin
			step_d = step_q + step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// File: hw/rtl/reference_count_table_top.sv
// Top level of the reference count table: command port, datapath and table memory.
`timescale 1ns / 1ps
// A command is taken at a rising edge where start is high and busy is low; busy
// then stays high until the command has finished, and the result follows as a
// one-cycle beat marked by done, which the receiver cannot hold off. The result
// ports keep their value after the beat until the next command is taken. An
// assign command searches the table for the old address and decrements its
// entry, freeing it and compacting the table when the count reaches zero; it
// then searches for the new address and increments that entry unless its count
// is saturated. The table sits in one RAM with a single registered read port,
// which is why a lookup walks the table one entry at a time, lowest index
// first. No clearing pass is needed after reset: only entries below the fill
// count are read.
module reference_count_table_top #(
	parameter int TABLE_DEPTH = 16,
	parameter int ADDR_WIDTH  = 32,
	parameter int COUNT_WIDTH = 16,
	localparam int IW = $clog2(TABLE_DEPTH),
	localparam int UW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  kind,
	input  logic [ADDR_WIDTH-1:0] old_addr,
	input  logic [ADDR_WIDTH-1:0] new_addr,
	output logic                  done,
	output logic                  freed_valid,
	output logic [ADDR_WIDTH-1:0] freed_addr,
	output logic                  status,
	output logic [UW-1:0]         entries_used
);
	import rct_pkg::*;

	localparam int DW = ADDR_WIDTH + COUNT_WIDTH;

	ctrl_t  ctrl;
	flags_t flags;
	logic   accept;

	// Latched command.
	logic                   kind_q;
	logic [ADDR_WIDTH-1:0]  old_q;
	logic [ADDR_WIDTH-1:0]  new_q;

	// Working registers of the datapath.
	logic [ADDR_WIDTH-1:0]  key_q;
	logic [UW-1:0]          idx_q;
	logic [IW-1:0]          slot_q;
	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [UW-1:0]          used_q;

	// Result registers.
	logic                   freed_valid_q;
	logic [ADDR_WIDTH-1:0]  freed_addr_q;
	logic                   status_q;
	logic                   done_q;

	// Table memory: each word holds an address above its count.
	logic                   ram_we;
	logic [IW-1:0]          ram_waddr;
	logic [DW-1:0]          ram_wdata;
	logic [IW-1:0]          ram_raddr;
	logic [DW-1:0]          ram_rdata;
	logic [ADDR_WIDTH-1:0]  rd_addr;
	logic [COUNT_WIDTH-1:0] rd_cnt;

	logic [UW-1:0]          used_dec;
	logic [UW:0]            idx_inc;
	logic                   full;

	assign accept   = start && !busy;
	assign rd_addr  = ram_rdata[DW-1:COUNT_WIDTH];
	assign rd_cnt   = ram_rdata[COUNT_WIDTH-1:0];
	assign used_dec = used_q - UW'(1);
	assign idx_inc  = {1'b0, idx_q} + (UW + 1)'(1);
	assign full     = (used_q >= UW'(TABLE_DEPTH));

	assign flags.start    = start;
	assign flags.kind     = kind_q;
	assign flags.old_skip = (old_q == '0) || (used_q == '0);
	assign flags.new_skip = (new_q == '0) || (used_q == '0);
	assign flags.match    = (rd_addr == key_q);
	assign flags.unsat    = (rd_cnt != {COUNT_WIDTH{1'b1}});
	assign flags.cnt_one  = (cnt_q == COUNT_WIDTH'(1));
	assign flags.more     = (idx_inc < {1'b0, used_q});

	rct_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// While compacting, the read port fetches the last entry; otherwise it
	// follows the scan index.
	assign ram_raddr = (ctrl.act == ACT_FREE_RD) ? used_dec[IW-1:0] : idx_q[IW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q;
		ram_wdata = {key_q, cnt_q};
		case (ctrl.act)
			ACT_DEC: begin
				ram_we    = 1'b1;
				ram_wdata = {key_q, cnt_q - COUNT_WIDTH'(1)};
			end
			ACT_FREE_WR: begin
				// The last entry moves into the freed slot.
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ACT_INC: begin
				ram_we    = 1'b1;
				ram_wdata = {key_q, cnt_q + COUNT_WIDTH'(1)};
			end
			ACT_REG: begin
				// A null address or a full table leaves the table untouched.
				ram_we    = !full && (new_q != '0);
				ram_waddr = used_q[IW-1:0];
				ram_wdata = {new_q, COUNT_WIDTH'(1)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	rct_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Command latch and working registers that carry only data.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			old_q  <= old_addr;
			new_q  <= new_addr;
		end
		case (ctrl.act)
			ACT_SETUP_OLD: begin
				key_q <= old_q;
				idx_q <= '0;
			end
			ACT_SETUP_NEW: begin
				key_q <= new_q;
				idx_q <= '0;
			end
			ACT_CMP: begin
				slot_q <= idx_q[IW-1:0];
				cnt_q  <= rd_cnt;
				idx_q  <= idx_inc[UW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Fill count, result registers and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q        <= '0;
			freed_valid_q <= 1'b0;
			freed_addr_q  <= '0;
			status_q      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				freed_valid_q <= 1'b0;
				freed_addr_q  <= '0;
				status_q      <= 1'b0;
			end
			case (ctrl.act)
				ACT_FREE_RD: begin
					used_q        <= used_dec;
					freed_valid_q <= 1'b1;
					freed_addr_q  <= key_q;
				end
				ACT_REG: begin
					if (full) begin
						status_q <= 1'b1;
					end else if (new_q != '0) begin
						used_q <= used_q + UW'(1);
					end
				end
				ACT_DONE: begin
					done_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign done         = done_q;
	assign freed_valid  = freed_valid_q;
	assign freed_addr   = freed_addr_q;
	assign status       = status_q;
	assign entries_used = used_q;

endmodule

// File: hw/rtl/rct_checker.sv
// Port-level checker for the reference count table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rct_checker #(
	parameter int TABLE_DEPTH = 16,
	parameter int ADDR_WIDTH  = 32,
	localparam int UW = $clog2(TABLE_DEPTH + 1)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  freed_valid,
	input logic [ADDR_WIDTH-1:0] freed_addr,
	input logic                  status,
	input logic [UW-1:0]         entries_used
);

	`RCT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`RCT_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`RCT_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`RCT_ASSERT_IMPL(a_freed_addr_zero, clk, arst_n, done && !freed_valid, freed_addr == '0)
	`RCT_ASSERT_IMPL(a_full_status, clk, arst_n, done && status, !freed_valid && (entries_used == UW'(TABLE_DEPTH)))

endmodule

bind reference_count_table_top rct_checker #(
	.TABLE_DEPTH (TABLE_DEPTH),
	.ADDR_WIDTH  (ADDR_WIDTH)
) u_rct_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.freed_valid  (freed_valid),
	.freed_addr   (freed_addr),
	.status       (status),
	.entries_used (entries_used)
);

// File: verif/tb_reference_count_table_top.sv
// Self-checking testbench for the reference count table, with its own table predictor.
`timescale 1ns / 1ps
// Every command beat that the block accepts is run through a local copy of the
// table at the moment of acceptance. The expected result is queued there and
// compared against the next done beat. The block takes one command at a time,
// so results come back strictly in order. Stimulus is driven at the falling
// edge, and outputs are sampled at the rising edge, which keeps the bench free
// of races.
module tb_reference_count_table_top;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_WIDTH  = 32;
	localparam int COUNT_WIDTH = 16;
	localparam int UW          = $clog2(TABLE_DEPTH + 1);

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [ADDR_WIDTH-1:0]  NULL_ADDR = '0;

	// Command kinds and status codes as the ports carry them.
	localparam logic KIND_REGISTER = 1'b0;
	localparam logic KIND_ASSIGN   = 1'b1;
	localparam logic STATUS_OK     = 1'b0;
	localparam logic STATUS_FULL   = 1'b1;

	// The slowest assign searches the table for the old address, frees and compacts
	// its entry, and then searches for the new address and increments it.
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_ITEMS  = 500;
	localparam int POOL_SIZE     = 12;

	typedef struct packed {
		logic                  freed_valid;
		logic [ADDR_WIDTH-1:0] freed_addr;
		logic                  status;
		logic [UW-1:0]         entries_used;
	} table_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  kind;
	logic [ADDR_WIDTH-1:0] old_addr;
	logic [ADDR_WIDTH-1:0] new_addr;
	logic                  done;
	logic                  freed_valid;
	logic [ADDR_WIDTH-1:0] freed_addr;
	logic                  status;
	logic [UW-1:0]         entries_used;

	reference_count_table_top #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.ADDR_WIDTH (ADDR_WIDTH),
		.COUNT_WIDTH(COUNT_WIDTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.old_addr    (old_addr),
		.new_addr    (new_addr),
		.done        (done),
		.freed_valid (freed_valid),
		.freed_addr  (freed_addr),
		.status      (status),
		.entries_used(entries_used)
	);

	// The bench's own view of the table. Only entries below tracked_fill mean anything.
	logic [ADDR_WIDTH-1:0]  tracked_addr  [TABLE_DEPTH];
	logic [COUNT_WIDTH-1:0] tracked_count [TABLE_DEPTH];
	int                     tracked_fill = 0;

	table_result_t pending_results[$];
	int            error_count = 0;
	int            burst_left  = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Lowest index that holds addr, or -1 when the address is not tracked.
	function automatic int find_entry(input logic [ADDR_WIDTH-1:0] addr);
		for (int i = 0; i < tracked_fill; i++)
			if (tracked_addr[i] == addr)
				return i;
		return -1;
	endfunction

	// Applies one command to the local table and returns the result that the
	// block must give for it.
	function automatic table_result_t update_ref_table(input logic k,
			input logic [ADDR_WIDTH-1:0] oa, input logic [ADDR_WIDTH-1:0] na);
		table_result_t r;
		int            slot;
		r = '0;
		if (k == KIND_REGISTER) begin
			// A full table refuses even a null address.
			if (tracked_fill >= TABLE_DEPTH) begin
				r.status = STATUS_FULL;
			end else if (na != NULL_ADDR) begin
				tracked_addr[tracked_fill]  = na;
				tracked_count[tracked_fill] = COUNT_WIDTH'(1);
				tracked_fill++;
			end
		end else begin
			// The old pointer is released first. When its count reaches zero, the last
			// entry is moved down into the freed slot.
			if (oa != NULL_ADDR) begin
				slot = find_entry(oa);
				if (slot >= 0) begin
					tracked_count[slot] = tracked_count[slot] - 1'b1;
					if (tracked_count[slot] == '0) begin
						r.freed_valid       = 1'b1;
						r.freed_addr        = oa;
						tracked_addr[slot]  = tracked_addr[tracked_fill - 1];
						tracked_count[slot] = tracked_count[tracked_fill - 1];
						tracked_fill--;
					end
				end
			end
			// The new pointer is then retained, and its count saturates at the top.
			if (na != NULL_ADDR) begin
				slot = find_entry(na);
				if (slot >= 0 && tracked_count[slot] != COUNT_MAX)
					tracked_count[slot] = tracked_count[slot] + 1'b1;
			end
		end
		r.entries_used = UW'(tracked_fill);
		return r;
	endfunction

	// Presents one command and holds it until the block takes it. Start stays
	// high on return, so that the next command can follow back to back.
	task automatic send_item(input logic k, input logic [ADDR_WIDTH-1:0] oa,
			input logic [ADDR_WIDTH-1:0] na);
		@(negedge clk);
		start    = 1'b1;
		kind     = k;
		old_addr = oa;
		new_addr = na;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(update_ref_table(k, oa, na));
	endtask

	// Drops start and puts noise on the command fields, which the block must
	// ignore while start is low.
	task automatic idle_cycles(input int n);
		@(negedge clk);
		start    = 1'b0;
		kind     = 1'($urandom());
		old_addr = $urandom();
		new_addr = $urandom();
		repeat (n - 1)
			@(negedge clk);
	endtask

	// The sender works in bursts of random length, with random gaps between them.
	// Because the gaps begin right after an acceptance, they fall across the early
	// steps of the block's work on the command that it has just taken.
	task automatic paced_send(input logic k, input logic [ADDR_WIDTH-1:0] oa,
			input logic [ADDR_WIDTH-1:0] na);
		send_item(k, oa, na);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_cycles($urandom_range(1, 12));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
			                                         : $urandom_range(0, 6);
		end
	endtask

	// Holds the sender off until every outstanding result beat has been checked.
	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Releases every tracked entry, one decrement at a time.
	task automatic empty_table();
		while (tracked_fill > 0)
			paced_send(KIND_ASSIGN, tracked_addr[0], NULL_ADDR);
	endtask

	// A pointer for an assign: mostly a live entry, and now and then null or a stray value.
	function automatic logic [ADDR_WIDTH-1:0] pick_pointer(input logic [ADDR_WIDTH-1:0] stray);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return NULL_ADDR;
		if (r == 1 || tracked_fill == 0)
			return stray;
		return tracked_addr[$urandom_range(0, tracked_fill - 1)];
	endfunction

	// Registers into an empty table: the null address, both extreme addresses and a duplicate.
	task automatic test_register_items();
		paced_send(KIND_REGISTER, NULL_ADDR, NULL_ADDR);
		paced_send(KIND_REGISTER, '1, 32'h0000_0001);
		paced_send(KIND_REGISTER, NULL_ADDR, 32'hFFFF_FFFF);
		paced_send(KIND_REGISTER, $urandom(), 32'h0000_0001);
		paced_send(KIND_REGISTER, NULL_ADDR, 32'hA5A5_5A5A);
		paced_send(KIND_REGISTER, NULL_ADDR, $urandom());
	endtask

	// Assigns that cover null and untracked pointers, increments and frees that
	// compact the table. The duplicate address is released at its lowest match.
	task automatic test_assign_items();
		paced_send(KIND_ASSIGN, NULL_ADDR, NULL_ADDR);
		paced_send(KIND_ASSIGN, 32'h1234_5678, 32'h8765_4321);
		paced_send(KIND_ASSIGN, NULL_ADDR, 32'hFFFF_FFFF);
		paced_send(KIND_ASSIGN, 32'hFFFF_FFFF, 32'h0000_0001);
		paced_send(KIND_ASSIGN, 32'h0000_0001, NULL_ADDR);
		paced_send(KIND_ASSIGN, 32'h0000_0001, NULL_ADDR);
		// With old and new the same at a count of one, the entry is freed first,
		// so the increment finds nothing.
		paced_send(KIND_ASSIGN, 32'hA5A5_5A5A, 32'hA5A5_5A5A);
		paced_send(KIND_ASSIGN, 32'hFFFF_FFFF, 32'h0000_0001);
	endtask

	// Fills the table, checks that a full table refuses registers, and then frees
	// a middle entry so that the last one moves into its slot.
	task automatic test_full_table();
		empty_table();
		for (int i = 0; i < TABLE_DEPTH; i++)
			paced_send(KIND_REGISTER, NULL_ADDR, {4'(i), 24'h5A_0000, 4'(15 - i)});
		paced_send(KIND_REGISTER, NULL_ADDR, 32'hDEAD_BEEF);
		paced_send(KIND_REGISTER, NULL_ADDR, NULL_ADDR);
		paced_send(KIND_ASSIGN, tracked_addr[5], tracked_addr[TABLE_DEPTH - 1]);
		paced_send(KIND_ASSIGN, tracked_addr[5], NULL_ADDR);
		paced_send(KIND_REGISTER, NULL_ADDR, 32'hDEAD_BEEF);
		paced_send(KIND_REGISTER, NULL_ADDR, 32'h7FFF_FFFF);
	endtask

	// Mostly well-formed traffic on a small pool of addresses, so that lookups hit
	// and entries are freed. Null, stray and duplicate pointers are mixed in.
	task automatic test_random_traffic();
		logic [ADDR_WIDTH-1:0] addr_pool [POOL_SIZE];
		logic                  k;
		logic [ADDR_WIDTH-1:0] oa;
		logic [ADDR_WIDTH-1:0] na;
		int                    reg_pct;
		foreach (addr_pool[i])
			addr_pool[i] = $urandom();
		addr_pool[0] = '1;
		addr_pool[1] = 32'h0000_0001;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Push the fill count towards the middle, while still letting it touch both ends.
			if (tracked_fill < 4)
				reg_pct = 70;
			else if (tracked_fill > 12)
				reg_pct = 20;
			else
				reg_pct = 40;
			if ($urandom_range(0, 99) < reg_pct) begin
				k  = KIND_REGISTER;
				oa = $urandom();
				case ($urandom_range(0, 9))
					0:       na = NULL_ADDR;
					1, 2:    na = $urandom();
					default: na = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
				endcase
			end else begin
				k  = KIND_ASSIGN;
				oa = pick_pointer(addr_pool[$urandom_range(0, POOL_SIZE - 1)]);
				na = ($urandom_range(0, 3) == 0) ? NULL_ADDR : pick_pointer($urandom());
			end
			paced_send(k, oa, na);
			if (n % 100 == 99)
				wait_drained();
		end
	endtask

	// Raises one entry's count well above one with back-to-back increments, and
	// then releases it one step at a time. Only the last release may free it.
	task automatic test_count_release();
		empty_table();
		paced_send(KIND_REGISTER, NULL_ADDR, 32'h8000_0001);
		wait_drained();
		repeat (8)
			send_item(KIND_ASSIGN, NULL_ADDR, 32'h8000_0001);
		paced_send(KIND_ASSIGN, 32'h8000_0001, 32'h8000_0001);
		repeat (9)
			paced_send(KIND_ASSIGN, 32'h8000_0001, NULL_ADDR);
		paced_send(KIND_REGISTER, NULL_ADDR, 32'h0000_0002);
	endtask

	// Compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no command outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (freed_valid !== want.freed_valid) begin
					$error("freed_valid: expected %0d, got %0d", want.freed_valid, freed_valid);
					error_count++;
				end
				if (freed_addr !== want.freed_addr) begin
					$error("freed_addr: expected %h, got %h", want.freed_addr, freed_addr);
					error_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					error_count++;
				end
				if (entries_used !== want.entries_used) begin
					$error("entries_used: expected %0d, got %0d", want.entries_used,
						entries_used);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		kind     = KIND_REGISTER;
		old_addr = NULL_ADDR;
		new_addr = NULL_ADDR;
		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;

		test_register_items();
		test_assign_items();
		test_full_table();
		test_random_traffic();
		test_count_release();

		wait_drained();
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// The timeout allows several times the run time that would follow if every
	// command were the slowest assign followed by the longest gap.
	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
